[sv/pfgb_pkg.sv]
// Shared constants and operation codes for the page frame buffer glyph blitter.
package pfgb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int FULL_PAGES   = PANEL_HEIGHT / 8;
  localparam int PART_ROWS    = PANEL_HEIGHT % 8;
  localparam int STORE_SIZE   = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W       = $clog2(STORE_SIZE);
  // wide enough for page * width + column over the whole 8-bit row range
  localparam int IDX_W        = 14;

  localparam int OP_W   = 2;
  localparam int COORD_W = 8;
  localparam int BYTE_W = 8;
  localparam int RPAGE_W = 3;
  localparam int RCOL_W = 7;
  localparam int PAGE_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_GLYPH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_RD_A  = 8'b0000_0100,
    S_WR_A  = 8'b0000_1000,
    S_RD_B  = 8'b0001_0000,
    S_WR_B  = 8'b0010_0000,
    S_RDQ   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

endpackage

[sv/page_framebuffer_glyph_blitter.sv]
// Page organized monochrome frame store with pixel write, glyph strip blit, clear and read.
//
// Input channel: in_valid_i / in_stall_o carry one operation per beat (op_i selects
// pixel write, glyph byte, clear store or read byte; the other fields are its operands).
// Output channel: out_valid_o / out_stall_i carry one pixel_byte_o beat per read.
// A beat is taken when valid is high and stall is low.
// The block runs one operation at a time through a single store (one read port, one
// write port) and one read-modify-write merge unit, sequenced by a small state machine:
//   pixel write  : accept, then read, merge and write back
//   glyph byte   : accept, then read and merge-write each touched page, 1 or 2 pages
//   read byte    : accept, then read the store, result lands in the output register
//   clear store  : accept, then sweep all STORE_SIZE bytes (1024), one byte per cycle
// A read passes S_RDQ (store read) and S_OUT, which loads the output when it is free.
// A waiting result does not block pixel, glyph or clear operations; only a new read
// waits in its output state until the pending beat is taken.
// After reset the block sweeps all STORE_SIZE bytes (1024) of the store to zero with
// in_stall_o high; the glyph cursor and origin reset to zero.
// While out_stall_i is high the result beat holds on the output ports.
module page_framebuffer_glyph_blitter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pfgb_pkg::OP_W-1:0]      op_i,
  input  logic [pfgb_pkg::COORD_W-1:0]   x_i,
  input  logic [pfgb_pkg::COORD_W-1:0]   y_i,
  input  logic                           pixel_on_i,
  input  logic [pfgb_pkg::BYTE_W-1:0]    glyph_byte_i,
  input  logic [pfgb_pkg::COORD_W-1:0]   glyph_width_i,
  input  logic                           invert_i,
  input  logic                           first_i,
  input  logic [pfgb_pkg::RPAGE_W-1:0]   read_page_i,
  input  logic [pfgb_pkg::RCOL_W-1:0]    read_col_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pfgb_pkg::BYTE_W-1:0]    pixel_byte_o
);
  import pfgb_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [COORD_W-1:0]  cursor_col_q, cursor_col_d;
  logic [COORD_W-1:0]  cursor_row_q, cursor_row_d;
  logic [COORD_W-1:0]  origin_col_q, origin_col_d;

  // latched operands of the operation in flight
  logic [COORD_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [2*BYTE_W-1:0] wmask_q, wmask_d;
  logic [2*BYTE_W-1:0] wdata_q, wdata_d;
  logic [RPAGE_W-1:0]  rpage_q, rpage_d;
  logic [RCOL_W-1:0]   rcol_q, rcol_d;

  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   pixel_byte_q, pixel_byte_d;

  logic [BYTE_W-1:0]   mem [STORE_SIZE];
  logic [BYTE_W-1:0]   rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [BYTE_W-1:0]   mem_wdata;

  logic                in_accept;
  logic                out_free;

  // glyph cursor arithmetic
  logic [COORD_W-1:0]  strip_col, strip_row, strip_org, next_col, col_span;
  logic [2:0]          row_shift;
  logic [BYTE_W-1:0]   glyph_bits;

  // shared merge unit
  logic                on_b;
  logic [PAGE_W-1:0]   cur_page;
  logic [BYTE_W-1:0]   cur_mask, cur_data;
  logic [IDX_W-1:0]    rmw_idx, rd_idx;
  logic                col_ok, rd_ok;

  function automatic logic [BYTE_W-1:0] page_rows(input logic [PAGE_W-1:0] page);
    logic [BYTE_W-1:0] rows;
    rows = '0;
    if ({1'b0, page} < 6'(FULL_PAGES)) begin
      rows = '1;
    end else if ({1'b0, page} == 6'(FULL_PAGES)) begin
      rows = BYTE_W'((1 << PART_ROWS) - 1);
    end
    return rows;
  endfunction

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    strip_col  = first_i ? x_i : cursor_col_q;
    strip_row  = first_i ? y_i : cursor_row_q;
    strip_org  = first_i ? x_i : origin_col_q;
    next_col   = strip_col + COORD_W'(1);
    col_span   = next_col - strip_org;
    row_shift  = (op_i == OP_GLYPH) ? strip_row[2:0] : y_i[2:0];
    glyph_bits = glyph_byte_i ^ {BYTE_W{invert_i}};
  end

  always_comb begin
    on_b     = (state_q == S_RD_B) || (state_q == S_WR_B);
    cur_page = on_b ? page_q + PAGE_W'(1) : page_q;
    col_ok   = {1'b0, col_q} < 9'(PANEL_WIDTH);
    cur_mask = (on_b ? wmask_q[2*BYTE_W-1:BYTE_W] : wmask_q[BYTE_W-1:0])
               & page_rows(cur_page) & {BYTE_W{col_ok}};
    cur_data = on_b ? wdata_q[2*BYTE_W-1:BYTE_W] : wdata_q[BYTE_W-1:0];
    rmw_idx  = IDX_W'(cur_page) * IDX_W'(PANEL_WIDTH) + IDX_W'(col_q);
    rd_idx   = IDX_W'(rpage_q) * IDX_W'(PANEL_WIDTH) + IDX_W'(rcol_q);
    rd_ok    = ({3'b0, rpage_q} < 6'(PAGE_COUNT)) && ({2'b0, rcol_q} < 9'(PANEL_WIDTH));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rmw_idx[ADDR_W-1:0];
    mem_wdata = (rdata_q & ~cur_mask) | (cur_data & cur_mask);
    mem_raddr = rd_idx[ADDR_W-1:0];
    if (state_q == S_RD_A || state_q == S_RD_B) begin
      mem_raddr = rmw_idx[ADDR_W-1:0];
    end
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_WR_A || state_q == S_WR_B) begin
      mem_we = (cur_mask != '0);
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    origin_col_d = origin_col_q;
    col_d        = col_q;
    page_d       = page_q;
    wmask_d      = wmask_q;
    wdata_d      = wdata_q;
    rpage_d      = rpage_q;
    rcol_d       = rcol_q;
    out_valid_d  = out_valid_q;
    pixel_byte_d = pixel_byte_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (op_i)
            OP_PIXEL: begin
              col_d   = x_i;
              page_d  = y_i[COORD_W-1:3];
              wmask_d = (2*BYTE_W)'(8'h01) << row_shift;
              wdata_d = pixel_on_i ? wmask_d : '0;
              state_d = S_RD_A;
            end
            OP_GLYPH: begin
              col_d   = strip_col;
              page_d  = strip_row[COORD_W-1:3];
              wmask_d = {{BYTE_W{1'b0}}, {BYTE_W{1'b1}}} << row_shift;
              wdata_d = {{BYTE_W{1'b0}}, glyph_bits} << row_shift;
              origin_col_d = strip_org;
              if (col_span == glyph_width_i) begin
                cursor_col_d = strip_org;
                cursor_row_d = strip_row + COORD_W'(8);
              end else begin
                cursor_col_d = next_col;
                cursor_row_d = strip_row;
              end
              state_d = S_RD_A;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            OP_READ: begin
              rpage_d = read_page_i;
              rcol_d  = read_col_i;
              state_d = S_RDQ;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_RD_A: state_d = S_WR_A;
      S_WR_A: begin
        // skip the lower page when nothing spills into it
        state_d = (wmask_q[2*BYTE_W-1:BYTE_W] != '0) ? S_RD_B : S_IDLE;
      end
      S_RD_B: state_d = S_WR_B;
      S_WR_B: state_d = S_IDLE;
      S_RDQ:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          pixel_byte_d = rd_ok ? rdata_q : '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      origin_col_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      origin_col_q <= origin_col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    page_q       <= page_d;
    wmask_q      <= wmask_d;
    wdata_q      <= wdata_d;
    rpage_q      <= rpage_d;
    rcol_q       <= rcol_d;
    pixel_byte_q <= pixel_byte_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_byte_q;

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDQ || state_q == S_OUT || state_q == S_IDLE) |-> !mem_we)
    else $error("store written outside a write state");

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result beat raised without a read");

  a_clear_full_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_CLEAR && state_q == S_IDLE) |-> $past(clr_q) == ADDR_W'(STORE_SIZE - 1))
    else $error("clear sweep ended early");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(pixel_byte_o) && out_valid_o)
    else $error("stalled result beat changed");

endmodule
